// File: rtl/core/cpio_nsp_pkg.sv
package cpio_nsp_pkg;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_NAME    = 3'd1,
		PH_NAMEPAD = 3'd2,
		PH_DATA    = 3'd3,
		PH_DATAPAD = 3'd4,
		PH_TRAILER = 3'd5
	} phase_t;

	localparam logic [2:0] REGION_HEADER  = 3'd0;
	localparam logic [2:0] REGION_IGNORED = 3'd5;

	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_BAD_MAGIC    = 3'd1;
	localparam logic [2:0] ERR_BAD_HEX      = 3'd2;
	localparam logic [2:0] ERR_SHORT_HEADER = 3'd3;
	localparam logic [2:0] ERR_SHORT_NAME   = 3'd4;
	localparam logic [2:0] ERR_SHORT_DATA   = 3'd5;

	localparam logic [1:0] KIND_DIR   = 2'd0;
	localparam logic [1:0] KIND_FILE  = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;

	localparam logic [31:0] MODE_TYPE_MASK = 32'o170000;
	localparam logic [31:0] MODE_TYPE_DIR  = 32'o040000;
	localparam logic [31:0] MODE_TYPE_REG  = 32'o100000;

	localparam logic [6:0] MAGIC_LEN   = 7'd6;
	localparam logic [6:0] HEADER_LAST = 7'd109;

	localparam logic [3:0] FIELD_MODE     = 4'd1;
	localparam logic [3:0] FIELD_FILESIZE = 4'd6;
	localparam logic [3:0] FIELD_NAMESIZE = 4'd11;
	localparam logic [2:0] DIGIT_LAST     = 3'd7;

	localparam logic [3:0] TRAILER_LEN  = 4'd10;
	localparam logic [3:0] NAME_IDX_MAX = 4'd11;

	localparam logic [7:0] MAGIC_CHARS [6] = '{8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31};
	localparam logic [7:0] TRAILER_CHARS [10] = '{
		8'h54, 8'h52, 8'h41, 8'h49, 8'h4c, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic       we;
		logic [1:0] start_phase;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  region;
		logic [1:0]  entry_type;
		logic [31:0] mode;
		logic [31:0] file_size;
		logic [31:0] name_size;
		logic        header_done;
		logic        entry_done;
		logic        trailer_seen;
		logic [2:0]  error_code;
	} result_t;

	function automatic logic [1:0] kind_of_mode(logic [31:0] m);
		logic [31:0] t;
		t = m & MODE_TYPE_MASK;
		if (t == MODE_TYPE_DIR)
			return KIND_DIR;
		if (t == MODE_TYPE_REG)
			return KIND_FILE;
		return KIND_OTHER;
	endfunction

	// bit 4: valid digit, bits 3:0: value
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c - 8'h30;
			return {1'b1, v[3:0]};
		end
		if (c inside {[8'h61:8'h66]}) begin
			v = c - 8'h57;
			return {1'b1, v[3:0]};
		end
		if (c inside {[8'h41:8'h46]}) begin
			v = c - 8'h37;
			return {1'b1, v[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

// File: rtl/core/cpio_nsp_if.sv
interface cpio_nsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface cpio_nsp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic [2:0]  region;
	logic [1:0]  entry_type;
	logic [31:0] mode;
	logic [31:0] file_size;
	logic [31:0] name_size;
	logic        header_done;
	logic        entry_done;
	logic        trailer_seen;
	logic [2:0]  error_code;

	modport source (
		output valid, output byte_out, output region, output entry_type, output mode,
		output file_size, output name_size, output header_done, output entry_done,
		output trailer_seen, output error_code, input ready
	);
	modport sink (
		input valid, input byte_out, input region, input entry_type, input mode,
		input file_size, input name_size, input header_done, input entry_done,
		input trailer_seen, input error_code, output ready
	);
endinterface

// File: rtl/core/cpio_nsp_parser.sv
module cpio_nsp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  cpio_nsp_pkg::item_t   item,
	input  cpio_nsp_pkg::cfg_t    cfg,
	output cpio_nsp_pkg::result_t result
);

	cpio_nsp_pkg::phase_t phase_q, n_phase, enter_stage;
	logic [6:0]  count_q, n_count, digit_pos;
	logic [31:0] acc_q, n_acc;
	logic [31:0] mode_q, n_mode;
	logic [31:0] file_size_q, n_file_size;
	logic [31:0] name_size_q, n_name_size;
	logic [31:0] rem_q, n_rem, rem_dec;
	logic [1:0]  byte_phase_q, n_byte_phase, pad;
	logic [3:0]  name_idx_q, n_name_idx;
	logic        tmatch_q, n_tmatch;
	logic        halted_q, n_halted;
	logic [4:0]  hex;
	logic [2:0]  region, err;
	logic        hdone, edone, do_enter;

	always_comb begin
		n_byte_phase = byte_phase_q + 2'd1;
		n_phase      = phase_q;
		n_count      = count_q;
		n_acc        = acc_q;
		n_mode       = mode_q;
		n_file_size  = file_size_q;
		n_name_size  = name_size_q;
		n_rem        = rem_q;
		n_name_idx   = name_idx_q;
		n_tmatch     = tmatch_q;
		n_halted     = halted_q;
		region       = cpio_nsp_pkg::REGION_IGNORED;
		err          = cpio_nsp_pkg::ERR_NONE;
		hdone        = 1'b0;
		edone        = 1'b0;
		do_enter     = 1'b0;
		enter_stage  = cpio_nsp_pkg::PH_NAME;
		pad          = 2'd3 - byte_phase_q;
		hex          = cpio_nsp_pkg::hex_digit(item.data_byte);
		rem_dec      = rem_q - 32'd1;
		digit_pos    = count_q - cpio_nsp_pkg::MAGIC_LEN;

		if (!halted_q && phase_q != cpio_nsp_pkg::PH_TRAILER) begin
			region = phase_q;
			case (phase_q)
				cpio_nsp_pkg::PH_HEADER: begin
					if (count_q == 7'd0) begin
						n_mode      = 32'd0;
						n_file_size = 32'd0;
						n_name_size = 32'd0;
						n_acc       = 32'd0;
					end
					if (count_q < cpio_nsp_pkg::MAGIC_LEN) begin
						if (item.data_byte != cpio_nsp_pkg::MAGIC_CHARS[count_q[2:0]])
							err = cpio_nsp_pkg::ERR_BAD_MAGIC;
					end else if (!hex[4]) begin
						err = cpio_nsp_pkg::ERR_BAD_HEX;
					end else begin
						n_acc = {n_acc[27:0], hex[3:0]};
						if (digit_pos[2:0] == cpio_nsp_pkg::DIGIT_LAST) begin
							case (digit_pos[6:3])
								cpio_nsp_pkg::FIELD_MODE:     n_mode = n_acc;
								cpio_nsp_pkg::FIELD_FILESIZE: n_file_size = n_acc;
								cpio_nsp_pkg::FIELD_NAMESIZE: n_name_size = n_acc;
								default: ;
							endcase
							n_acc = 32'd0;
						end
					end
					if (err == cpio_nsp_pkg::ERR_NONE) begin
						if (count_q >= cpio_nsp_pkg::HEADER_LAST) begin
							hdone       = 1'b1;
							n_name_idx  = 4'd0;
							n_tmatch    = 1'b1;
							enter_stage = cpio_nsp_pkg::PH_NAME;
							do_enter    = 1'b1;
						end else begin
							n_count = count_q + 7'd1;
						end
					end
				end
				cpio_nsp_pkg::PH_NAME: begin
					if (name_idx_q < cpio_nsp_pkg::TRAILER_LEN) begin
						if (item.data_byte != cpio_nsp_pkg::TRAILER_CHARS[name_idx_q])
							n_tmatch = 1'b0;
					end else if (name_idx_q == cpio_nsp_pkg::TRAILER_LEN) begin
						if (item.data_byte != 8'd0)
							n_tmatch = 1'b0;
					end
					if (name_idx_q < cpio_nsp_pkg::NAME_IDX_MAX)
						n_name_idx = name_idx_q + 4'd1;
					n_rem = rem_dec;
					if (rem_dec == 32'd0) begin
						if (n_tmatch && n_name_idx >= cpio_nsp_pkg::TRAILER_LEN) begin
							n_phase = cpio_nsp_pkg::PH_TRAILER;
							edone   = 1'b1;
						end else begin
							enter_stage = cpio_nsp_pkg::PH_NAMEPAD;
							do_enter    = 1'b1;
						end
					end
				end
				default: begin
					n_rem = rem_dec;
					if (rem_dec == 32'd0) begin
						enter_stage = cpio_nsp_pkg::phase_t'(phase_q + 3'd1);
						do_enter    = 1'b1;
					end
				end
			endcase

			// skip empty regions
			if (do_enter) begin
				if (enter_stage <= cpio_nsp_pkg::PH_NAME && n_name_size != 32'd0) begin
					n_phase = cpio_nsp_pkg::PH_NAME;
					n_rem   = n_name_size;
				end else if (enter_stage <= cpio_nsp_pkg::PH_NAMEPAD && pad != 2'd0) begin
					n_phase = cpio_nsp_pkg::PH_NAMEPAD;
					n_rem   = {30'd0, pad};
				end else if (enter_stage <= cpio_nsp_pkg::PH_DATA && n_file_size != 32'd0) begin
					n_phase = cpio_nsp_pkg::PH_DATA;
					n_rem   = n_file_size;
				end else if (enter_stage <= cpio_nsp_pkg::PH_DATAPAD && pad != 2'd0) begin
					n_phase = cpio_nsp_pkg::PH_DATAPAD;
					n_rem   = {30'd0, pad};
				end else begin
					n_phase = cpio_nsp_pkg::PH_HEADER;
					n_count = 7'd0;
					n_rem   = 32'd0;
					edone   = 1'b1;
				end
			end

			if (err != cpio_nsp_pkg::ERR_NONE) begin
				n_halted = 1'b1;
			end else if (item.end_of_input) begin
				if (n_phase == cpio_nsp_pkg::PH_HEADER && n_count != 7'd0)
					err = cpio_nsp_pkg::ERR_SHORT_HEADER;
				else if (n_phase == cpio_nsp_pkg::PH_NAME)
					err = cpio_nsp_pkg::ERR_SHORT_NAME;
				else if ((n_phase == cpio_nsp_pkg::PH_NAMEPAD || n_phase == cpio_nsp_pkg::PH_DATA)
						&& cpio_nsp_pkg::kind_of_mode(n_mode) == cpio_nsp_pkg::KIND_FILE)
					err = cpio_nsp_pkg::ERR_SHORT_DATA;
				n_halted = 1'b1;
			end
		end else if (item.end_of_input) begin
			n_halted = 1'b1;
		end

		result.byte_out     = item.data_byte;
		result.region       = region;
		result.entry_type   = cpio_nsp_pkg::kind_of_mode(n_mode);
		result.mode         = n_mode;
		result.file_size    = n_file_size;
		result.name_size    = n_name_size;
		result.header_done  = hdone;
		result.entry_done   = edone;
		result.trailer_seen = (n_phase == cpio_nsp_pkg::PH_TRAILER);
		result.error_code   = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cpio_nsp_pkg::PH_HEADER;
			count_q      <= 7'd0;
			acc_q        <= 32'd0;
			mode_q       <= 32'd0;
			file_size_q  <= 32'd0;
			name_size_q  <= 32'd0;
			rem_q        <= 32'd0;
			byte_phase_q <= 2'd0;
			name_idx_q   <= 4'd0;
			tmatch_q     <= 1'b1;
			halted_q     <= 1'b0;
		end else if (cfg.we) begin
			byte_phase_q <= cfg.start_phase;
		end else if (step) begin
			phase_q      <= n_phase;
			count_q      <= n_count;
			acc_q        <= n_acc;
			mode_q       <= n_mode;
			file_size_q  <= n_file_size;
			name_size_q  <= n_name_size;
			rem_q        <= n_rem;
			byte_phase_q <= n_byte_phase;
			name_idx_q   <= n_name_idx;
			tmatch_q     <= n_tmatch;
			halted_q     <= n_halted;
		end
	end

endmodule

// File: rtl/core/cpio_newc_stream_parser_core.sv
// channel   dir  handshake      payload
// in_ch     in   valid/ready    data_byte, end_of_input
// out_ch    out  valid/ready    byte_out, region, entry_type, mode, file_size,
//                               name_size, header_done, entry_done, trailer_seen,
//                               error_code
// cfg       in   cfg_we         cfg_wdata (start_phase)
//
// One byte per cycle sustained while the output is not stalled.
// The byte is held in an input register, the parse step runs between it and the
// output register, and the per-entry state advances once per transaction.
// Reset clears the parse state; the byte phase restarts at zero until cfg_we.
// A stalled output keeps one result and one byte in flight before in_ch.ready drops.
module cpio_newc_stream_parser_core (
	input  logic                   clk,
	input  logic                   arst_n,
	cpio_nsp_in_if.sink            in_ch,
	cpio_nsp_out_if.source         out_ch,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_wdata
);

	logic                  valid_s1;
	cpio_nsp_pkg::item_t   item_s1;
	logic                  out_valid_q;
	cpio_nsp_pkg::result_t out_q;
	cpio_nsp_pkg::result_t result;
	cpio_nsp_pkg::cfg_t    cfg;
	logic                  advance;
	logic                  in_ready;

	assign advance  = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ready = !valid_s1 || advance;
	assign in_ch.ready = in_ready;

	assign cfg.we          = cfg_we;
	assign cfg.start_phase = cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			item_s1.data_byte    <= in_ch.data_byte;
			item_s1.end_of_input <= in_ch.end_of_input;
		end
	end

	cpio_nsp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= result;
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.byte_out     = out_q.byte_out;
	assign out_ch.region       = out_q.region;
	assign out_ch.entry_type   = out_q.entry_type;
	assign out_ch.mode         = out_q.mode;
	assign out_ch.file_size    = out_q.file_size;
	assign out_ch.name_size    = out_q.name_size;
	assign out_ch.header_done  = out_q.header_done;
	assign out_ch.entry_done   = out_q.entry_done;
	assign out_ch.trailer_seen = out_q.trailer_seen;
	assign out_ch.error_code   = out_q.error_code;

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ch.ready))
		else $error("input stalled while a stage was free");

	a_error_not_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.error_code != cpio_nsp_pkg::ERR_NONE)
			|-> out_q.region != cpio_nsp_pkg::REGION_IGNORED)
		else $error("error reported on an ignored byte");

	a_header_done_region: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.header_done) |-> out_q.region == cpio_nsp_pkg::REGION_HEADER)
		else $error("header_done outside the header region");

	a_trailer_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.trailer_seen) |=> (!advance || result.trailer_seen))
		else $error("trailer_seen dropped before reset");

endmodule
